// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define OVL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ordered value list check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define OVL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ordered value list check failed");

`endif

// ===== rtl/core/ovl_pkg.sv =====
// Types and codes shared by the ordered value list engine and its cells.
package ovl_pkg;

    localparam int unsigned ValueWidth = 32;

    // Operation kind carried on s_tuser
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_INSERT = 2'd2,
        KIND_DUMP   = 2'd3
    } kind_t;

    // Result status carried on m_tuser
    typedef enum logic [2:0] {
        STAT_DONE      = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_ENTRY     = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    // Command broadcast to every cell in the row
    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_APPEND = 3'd1,
        OP_DELETE = 3'd2,
        OP_INSERT = 3'd3,
        OP_ROTATE = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [ValueWidth-1:0]  key;
        logic [ValueWidth-1:0]  new_value;
        logic [ValueWidth-1:0]  head;
    } cell_cmd_t;

endpackage

// ===== rtl/core/ovl_cell.sv =====
// One list cell: holds an entry and shifts with its neighbours on delete, insert and rotate.
module ovl_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ovl_pkg::cell_cmd_t             cmd,
    input  logic [ovl_pkg::ValueWidth-1:0] prev_value,
    input  logic                           prev_occ,
    input  logic [ovl_pkg::ValueWidth-1:0] next_value,
    input  logic                           next_occ,
    input  logic                           found_in,
    output logic                           found_out,
    output logic [ovl_pkg::ValueWidth-1:0] value,
    output logic                           occ
);

    logic [ovl_pkg::ValueWidth-1:0] value_reg, value_next;
    logic                           occ_reg, occ_next;
    logic                           match;

    // match only counts on a live entry; found_out is the running prefix
    assign match     = occ_reg && (value_reg == cmd.key);
    assign found_out = found_in | match;
    assign value     = value_reg;
    assign occ       = occ_reg;

    always_comb begin
        value_next = value_reg;
        occ_next   = occ_reg;
        unique case (cmd.op)
            ovl_pkg::OP_APPEND: begin
                // first free cell after an occupied one takes the key
                if (!occ_reg && prev_occ) begin
                    value_next = cmd.key;
                    occ_next   = 1'b1;
                end
            end
            ovl_pkg::OP_DELETE: begin
                // from the first match onwards, pull from the right
                if (found_out) begin
                    value_next = next_value;
                    occ_next   = next_occ;
                end
            end
            ovl_pkg::OP_INSERT: begin
                // past the first match push right; the match cell takes the new value
                if (found_in) begin
                    value_next = prev_value;
                    occ_next   = prev_occ;
                end else if (match) begin
                    value_next = cmd.new_value;
                end
            end
            ovl_pkg::OP_ROTATE: begin
                // shift left; the tail wraps round to the old head
                if (occ_reg) begin
                    value_next = next_occ ? next_value : cmd.head;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// ===== rtl/core/ordered_value_list_engine.sv =====
// Top level of the ordered value list engine: cell row, sequencer, output register.
//
// Input stream (s_): one transfer per operation. s_tuser carries the kind
// (append, delete, insert before key, dump); s_tdata carries the key in the
// low word and the new value for insert in the high word.
// Result stream (m_): m_tuser is the status, m_tdata the entry value (zero
// unless a dump entry), m_tlast marks the final result of an operation.
// Append, delete and insert compare and shift across all cells at once and
// finish in the accepting cycle; the single result appears in the next one.
// These run at one per cycle while the receiver keeps up. A dump of N
// entries first enters the dump state and then, while the receiver keeps
// up, emits one entry per cycle by rotating the row; an empty dump gives
// one result. Entries are read from the head cell as the row rotates.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result. While the receiver stalls, the result stays in the output
// register and no new operation is taken.
module ordered_value_list_engine #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] new_value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned VW = ovl_pkg::ValueWidth;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } fsm_state_t;

    fsm_state_t          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       left_reg, left_next;
    logic                m_valid_reg, m_valid_next;
    ovl_pkg::status_t    m_status_reg, m_status_next;
    logic [VW-1:0]       m_value_reg, m_value_next;
    logic                m_last_reg, m_last_next;

    ovl_pkg::cell_cmd_t  cmd;
    ovl_pkg::kind_t      kind;
    logic [VW-1:0]       cell_value [CAPACITY];
    logic                cell_occ   [CAPACITY];
    logic                found_c    [CAPACITY+1];
    logic                out_free, accept, full, found_all;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign kind      = ovl_pkg::kind_t'(s_tuser);
    assign full      = cell_occ[CAPACITY-1];
    assign found_all = found_c[CAPACITY];

    // Cell row: found chain runs left to right
    assign found_c[0] = 1'b0;
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VW-1:0] pv, nv;
        logic          po, no;
        if (i == 0) begin : g_first
            assign pv = '0;
            assign po = 1'b1;
        end else begin : g_mid
            assign pv = cell_value[i-1];
            assign po = cell_occ[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign nv = '0;
            assign no = 1'b0;
        end else begin : g_body
            assign nv = cell_value[i+1];
            assign no = cell_occ[i+1];
        end
        ovl_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .prev_value (pv),
            .prev_occ   (po),
            .next_value (nv),
            .next_occ   (no),
            .found_in   (found_c[i]),
            .found_out  (found_c[i+1]),
            .value      (cell_value[i]),
            .occ        (cell_occ[i])
        );
    end

    // Sequencer and result generation
    always_comb begin
        cmd.op        = ovl_pkg::OP_NOP;
        cmd.key       = s_tdata[31:0];
        cmd.new_value = s_tdata[63:32];
        cmd.head      = cell_value[0];
        state_next    = state_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_value_next = '0;
                    m_last_next  = 1'b1;
                    case (kind)
                        ovl_pkg::KIND_APPEND: begin
                            m_valid_next = 1'b1;
                            if (full) begin
                                m_status_next = ovl_pkg::STAT_FULL;
                            end else begin
                                cmd.op        = ovl_pkg::OP_APPEND;
                                count_next    = count_reg + CW'(1);
                                m_status_next = ovl_pkg::STAT_DONE;
                            end
                        end
                        ovl_pkg::KIND_DELETE: begin
                            m_valid_next = 1'b1;
                            cmd.op       = ovl_pkg::OP_DELETE;
                            if (found_all) begin
                                count_next    = count_reg - CW'(1);
                                m_status_next = ovl_pkg::STAT_DONE;
                            end else begin
                                m_status_next = ovl_pkg::STAT_NOT_FOUND;
                            end
                        end
                        ovl_pkg::KIND_INSERT: begin
                            m_valid_next = 1'b1;
                            if (!found_all) begin
                                m_status_next = ovl_pkg::STAT_NOT_FOUND;
                            end else if (full) begin
                                m_status_next = ovl_pkg::STAT_FULL;
                            end else begin
                                cmd.op        = ovl_pkg::OP_INSERT;
                                count_next    = count_reg + CW'(1);
                                m_status_next = ovl_pkg::STAT_DONE;
                            end
                        end
                        default: begin
                            // dump: empty list answers at once, else start rotating
                            if (count_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = ovl_pkg::STAT_EMPTY;
                            end else begin
                                left_next  = count_reg;
                                state_next = ST_DUMP;
                            end
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    cmd.op        = ovl_pkg::OP_ROTATE;
                    m_valid_next  = 1'b1;
                    m_status_next = ovl_pkg::STAT_ENTRY;
                    m_value_next  = cell_value[0];
                    m_last_next   = (left_reg == CW'(1));
                    left_next     = left_reg - CW'(1);
                    if (left_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/core/ovl_checker.sv =====
// Port-level checker for the ordered value list engine, bound to the top level.
`include "assert_macros.svh"

module ovl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result transfer holds its payload
    `OVL_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // only dump entries carry a value
    `OVL_ASSERT_NOW(a_value_zero, m_tvalid && (m_tuser != ovl_pkg::STAT_ENTRY), m_tdata == '0)

    // every non-entry status closes its operation
    `OVL_ASSERT_NOW(a_single_last, m_tvalid && (m_tuser != ovl_pkg::STAT_ENTRY), m_tlast)

    // status stays within the defined codes
    `OVL_ASSERT_NOW(a_status_range, m_tvalid, m_tuser <= ovl_pkg::STAT_EMPTY)

endmodule

bind ordered_value_list_engine ovl_checker u_ovl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
